FILE: design/bpms_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the bit-parallel matching statistics engine.
// No dependencies.

package bpms_pkg;

    localparam int PATTERN_MAX   = 64;
    localparam int ALPHABET_SIZE = 32;
    localparam int BOUND_BITS    = 32;

    localparam int COL_W     = 64;
    localparam int POS_W     = $clog2(PATTERN_MAX);
    localparam int SYM_W     = 8;
    localparam int SYM_IDX_W = $clog2(ALPHABET_SIZE);
    localparam int KIND_W    = 3;
    localparam int DEPTH_W   = 8;
    localparam int CFG_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int SHIFT_W   = $clog2(COL_W);
    localparam int INDEX_W   = 6;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MATCH   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DUMP    = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_STOP       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SYMBOL = 2'd2;

    localparam logic [CFG_W-1:0] PATTERN_LENGTH_RESET = 7'd64;

    typedef struct packed {
        logic                 clear;
        logic                 load;
        logic [POS_W-1:0]     pos;
        logic [SYM_IDX_W-1:0] sym;
    } mask_cmd_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]    length;
        logic [BOUND_BITS-1:0] left;
        logic [BOUND_BITS-1:0] right;
    } entry_t;

endpackage

FILE: design/bpms_masks.sv
`timescale 1ns / 1ps
// Per-symbol match-position mask bank with load, clear and one read port.
// Depends on bpms_pkg.

module bpms_masks
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  bpms_pkg::mask_cmd_t            cmd,
    input  logic [bpms_pkg::SYM_IDX_W-1:0] rd_sym,
    output logic [bpms_pkg::COL_W-1:0]     rd_mask
);
    import bpms_pkg::*;

    logic [COL_W-1:0] mask_reg [ALPHABET_SIZE];
    logic [COL_W-1:0] pos_bit;

    assign pos_bit = COL_W'(1) << cmd.pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                mask_reg[i] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                mask_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                if (SYM_IDX_W'(i) == cmd.sym)
                begin
                    mask_reg[i] <= mask_reg[i] | pos_bit;
                end
                else
                begin
                    mask_reg[i] <= mask_reg[i] & ~pos_bit;
                end
            end
        end
    end

    assign rd_mask = mask_reg[rd_sym];

endmodule

FILE: design/bitparallel_matching_statistics.sv
`timescale 1ns / 1ps
// Top level of the bit-parallel matching statistics engine: sequencer, table, APB length register.
// Depends on bpms_pkg and bpms_masks.
// Load, clear, start search: busy stays low, result strobe in the next cycle; kinds 6, 7: none.
// Advance: busy in the shift step (mask registered, then shift); a bad symbol acts like a load.
// Full match: a table read per position below the pattern length, then a table write per set bit.
// Dump: a read then an output state per entry, one per position in use; the receiver never stalls.
// Reset clears masks, table valid bits and sets pattern_length to 64.

module bitparallel_matching_statistics
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [bpms_pkg::KIND_W-1:0]     kind,
    input  logic [bpms_pkg::POS_W-1:0]      position,
    input  logic [bpms_pkg::SYM_W-1:0]      symbol,
    input  logic [bpms_pkg::COL_W-1:0]      column_in,
    input  logic [bpms_pkg::DEPTH_W-1:0]    depth,
    input  logic [bpms_pkg::BOUND_BITS-1:0] left_bound,
    input  logic [bpms_pkg::BOUND_BITS-1:0] right_bound,
    output logic                            done,
    output logic [bpms_pkg::COL_W-1:0]      column_out,
    output logic [bpms_pkg::STATUS_W-1:0]   status,
    output logic [bpms_pkg::INDEX_W-1:0]    entry_index,
    output logic [bpms_pkg::DEPTH_W-1:0]    match_length,
    output logic [bpms_pkg::BOUND_BITS-1:0] witness_left,
    output logic [bpms_pkg::BOUND_BITS-1:0] witness_right,
    output logic                            last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import bpms_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_MATCH_RD,
        ST_MATCH_WR,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [POS_W-1:0]      idx_reg, idx_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [COL_W-1:0]      mask_reg, mask_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic [BOUND_BITS-1:0] lb_reg, lb_next;
    logic [BOUND_BITS-1:0] rb_reg, rb_next;
    logic [PATTERN_MAX-1:0] valid_reg, valid_next;
    logic [CFG_W-1:0]      pattern_length_reg, pattern_length_next;

    logic                  done_reg, done_next;
    logic [COL_W-1:0]      column_out_reg, column_out_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [INDEX_W-1:0]    entry_index_reg, entry_index_next;
    logic [DEPTH_W-1:0]    match_length_reg, match_length_next;
    logic [BOUND_BITS-1:0] witness_left_reg, witness_left_next;
    logic [BOUND_BITS-1:0] witness_right_reg, witness_right_next;
    logic                  last_reg, last_next;

    entry_t                table_mem [PATTERN_MAX];
    entry_t                rd_data_reg;
    logic                  rd_valid_reg;
    entry_t                rd_entry;
    entry_t                wr_entry;
    logic                  mem_we;

    mask_cmd_t             mask_cmd;
    logic [COL_W-1:0]      rd_mask;

    logic                  accept;
    logic                  symbol_ok;
    logic [CFG_W-1:0]      eff_len;
    logic [POS_W-1:0]      last_idx;
    logic [COL_W-1:0]      len_mask;
    logic [DEPTH_W-1:0]    shift_amt;
    logic [COL_W-1:0]      adv_col;
    logic [COL_W-1:0]      match_col;
    logic                  cfg_write;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign symbol_ok = (32'(symbol) < ALPHABET_SIZE);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? 32'(pattern_length_reg) : 32'd0;

    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            eff_len = CFG_W'(1);
        end
        else if (32'(pattern_length_reg) > PATTERN_MAX)
        begin
            eff_len = CFG_W'(PATTERN_MAX);
        end
        else
        begin
            eff_len = pattern_length_reg;
        end
    end

    assign last_idx = POS_W'(eff_len - CFG_W'(1));
    assign len_mask = (32'(eff_len) >= COL_W) ? {COL_W{1'b1}}
                                              : (COL_W'(1) << eff_len[SHIFT_W-1:0]) - COL_W'(1);

    // Shift unit for advance.
    assign shift_amt = depth_reg - DEPTH_W'(1);
    always_comb
    begin
        if (depth_reg <= DEPTH_W'(1))
        begin
            adv_col = mask_reg;
        end
        else if (32'(shift_amt) >= COL_W)
        begin
            adv_col = '0;
        end
        else
        begin
            adv_col = col_reg & (mask_reg >> shift_amt[SHIFT_W-1:0]);
        end
    end

    assign match_col = column_in & len_mask;

    assign mask_cmd.clear = accept && (kind == KIND_CLEAR);
    assign mask_cmd.load  = accept && (kind == KIND_LOAD) && symbol_ok
                            && (32'(position) < PATTERN_MAX);
    assign mask_cmd.pos   = position;
    assign mask_cmd.sym   = symbol[SYM_IDX_W-1:0];

    bpms_masks u_masks
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mask_cmd),
        .rd_sym  (symbol[SYM_IDX_W-1:0]),
        .rd_mask (rd_mask)
    );

    assign rd_entry        = rd_valid_reg ? rd_data_reg : '0;
    assign wr_entry.length = depth_reg;
    assign wr_entry.left   = lb_reg;
    assign wr_entry.right  = rb_reg;
    assign mem_we          = (state_reg == ST_MATCH_WR) && (rd_entry.length < depth_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[idx_reg] <= wr_entry;
        end
        rd_data_reg  <= table_mem[idx_reg];
        rd_valid_reg <= valid_reg[idx_reg];
    end

    always_comb
    begin
        state_next          = state_reg;
        idx_next            = idx_reg;
        col_next            = col_reg;
        mask_next           = mask_reg;
        depth_next          = depth_reg;
        lb_next             = lb_reg;
        rb_next             = rb_reg;
        valid_next          = valid_reg;
        pattern_length_next = pattern_length_reg;
        done_next           = 1'b0;
        column_out_next     = column_out_reg;
        status_next         = status_reg;
        entry_index_next    = entry_index_reg;
        match_length_next   = match_length_reg;
        witness_left_next   = witness_left_reg;
        witness_right_next  = witness_right_reg;
        last_next           = last_reg;

        if (cfg_write)
        begin
            pattern_length_next = pwdata[CFG_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    column_out_next    = '0;
                    status_next        = STATUS_OK;
                    entry_index_next   = '0;
                    match_length_next  = '0;
                    witness_left_next  = '0;
                    witness_right_next = '0;
                    last_next          = 1'b1;
                    idx_next           = '0;
                    depth_next         = depth;
                    lb_next            = left_bound;
                    rb_next            = right_bound;
                    case (kind)
                        KIND_LOAD, KIND_CLEAR:
                        begin
                            done_next = 1'b1;
                            if (kind == KIND_LOAD && !symbol_ok)
                            begin
                                status_next = STATUS_BAD_SYMBOL;
                            end
                        end
                        KIND_START:
                        begin
                            done_next       = 1'b1;
                            column_out_next = {COL_W{1'b1}};
                            for (int i = 0; i < PATTERN_MAX; i++)
                            begin
                                if (32'(i) < 32'(eff_len))
                                begin
                                    valid_next[i] = 1'b0;
                                end
                            end
                        end
                        KIND_ADVANCE:
                        begin
                            if (!symbol_ok)
                            begin
                                done_next   = 1'b1;
                                status_next = STATUS_BAD_SYMBOL;
                            end
                            else
                            begin
                                mask_next  = rd_mask;
                                col_next   = column_in;
                                state_next = ST_ADV;
                            end
                        end
                        KIND_MATCH:
                        begin
                            if (match_col == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STATUS_STOP;
                            end
                            else
                            begin
                                col_next   = match_col;
                                state_next = ST_MATCH_RD;
                            end
                        end
                        KIND_DUMP:
                        begin
                            state_next = ST_DUMP_RD;
                        end
                        default:
                        begin
                            last_next = last_reg;
                        end
                    endcase
                end
            end
            ST_ADV:
            begin
                done_next       = 1'b1;
                column_out_next = adv_col;
                status_next     = ((adv_col & len_mask) == '0) ? STATUS_STOP : STATUS_OK;
                state_next      = ST_IDLE;
            end
            ST_MATCH_RD:
            begin
                if (col_reg[idx_reg])
                begin
                    state_next = ST_MATCH_WR;
                end
                else if (idx_reg == last_idx)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + POS_W'(1);
                end
            end
            ST_MATCH_WR:
            begin
                if (mem_we)
                begin
                    valid_next[idx_reg] = 1'b1;
                end
                if (idx_reg == last_idx)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + POS_W'(1);
                    state_next = ST_MATCH_RD;
                end
            end
            ST_DUMP_RD:
            begin
                state_next = ST_DUMP_OUT;
            end
            ST_DUMP_OUT:
            begin
                done_next          = 1'b1;
                column_out_next    = '0;
                status_next        = STATUS_OK;
                entry_index_next   = INDEX_W'(idx_reg);
                match_length_next  = rd_entry.length;
                witness_left_next  = rd_entry.left;
                witness_right_next = rd_entry.right;
                last_next          = (idx_reg == last_idx);
                if (idx_reg == last_idx)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + POS_W'(1);
                    state_next = ST_DUMP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            valid_reg          <= '0;
            pattern_length_reg <= PATTERN_LENGTH_RESET;
            done_reg           <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            valid_reg          <= valid_next;
            pattern_length_reg <= pattern_length_next;
            done_reg           <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg           <= idx_next;
        col_reg           <= col_next;
        mask_reg          <= mask_next;
        depth_reg         <= depth_next;
        lb_reg            <= lb_next;
        rb_reg            <= rb_next;
        column_out_reg    <= column_out_next;
        status_reg        <= status_next;
        entry_index_reg   <= entry_index_next;
        match_length_reg  <= match_length_next;
        witness_left_reg  <= witness_left_next;
        witness_right_reg <= witness_right_next;
        last_reg          <= last_next;
    end

    assign done          = done_reg;
    assign column_out    = column_out_reg;
    assign status        = status_reg;
    assign entry_index   = entry_index_reg;
    assign match_length  = match_length_reg;
    assign witness_left  = witness_left_reg;
    assign witness_right = witness_right_reg;
    assign last          = last_reg;

`ifndef SYNTHESIS
    a_adv_enters_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_ADVANCE && symbol_ok) |=> (state_reg == ST_ADV))
        else $error("advance transfer did not enter the shift step");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MATCH_WR) |-> ($past(state_reg) == ST_MATCH_RD))
        else $error("table write without a preceding table read");

    a_only_dump_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !last_reg) |-> ($past(state_reg) == ST_DUMP_OUT))
        else $error("non-final result outside a dump");

    a_bad_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == STATUS_BAD_SYMBOL) |-> (column_out_reg == '0))
        else $error("bad-symbol result carries a column");
`endif

endmodule

FILE: sim/bitparallel_matching_statistics_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitparallel_matching_statistics: directed and random walk
// transfers with an in-bench predictor of masks and match table. Depends on bpms_pkg.

module bitparallel_matching_statistics_test;

    import bpms_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO       = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI       = 3'd7;
    localparam logic [2:0]        ADDR_PATTERN_LENGTH = 3'd0;
    localparam int                QUIET_CYCLES        = 8;
    localparam int                CYCLE_LIMIT         = 400000;
    localparam int                RANDOM_ITEMS        = 400;

    typedef struct packed {
        logic [COL_W-1:0]      column;
        logic [STATUS_W-1:0]   status;
        logic [INDEX_W-1:0]    index;
        logic [DEPTH_W-1:0]    length;
        logic [BOUND_BITS-1:0] left;
        logic [BOUND_BITS-1:0] right;
        logic                  last;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [KIND_W-1:0]     kind;
    logic [POS_W-1:0]      position;
    logic [SYM_W-1:0]      symbol;
    logic [COL_W-1:0]      column_in;
    logic [DEPTH_W-1:0]    depth;
    logic [BOUND_BITS-1:0] left_bound;
    logic [BOUND_BITS-1:0] right_bound;
    logic                  done;
    logic [COL_W-1:0]      column_out;
    logic [STATUS_W-1:0]   status;
    logic [INDEX_W-1:0]    entry_index;
    logic [DEPTH_W-1:0]    match_length;
    logic [BOUND_BITS-1:0] witness_left;
    logic [BOUND_BITS-1:0] witness_right;
    logic                  last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    logic [COL_W-1:0]      symbol_mask [ALPHABET_SIZE] = '{default: '0};
    logic [DEPTH_W-1:0]    best_len [PATTERN_MAX] = '{default: '0};
    logic [BOUND_BITS-1:0] best_left [PATTERN_MAX] = '{default: '0};
    logic [BOUND_BITS-1:0] best_right [PATTERN_MAX] = '{default: '0};
    logic [CFG_W-1:0]      pattern_len = PATTERN_LENGTH_RESET;

    outcome_t              expected_results [$];
    outcome_t              oldest;
    logic [COL_W-1:0]      walk_column;
    logic [STATUS_W-1:0]   walk_status;
    int                    items_sent;
    int                    results_checked;
    int                    mismatches;
    int                    length_settings;
    int                    cycle_count;

    bitparallel_matching_statistics DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .position      (position),
        .symbol        (symbol),
        .column_in     (column_in),
        .depth         (depth),
        .left_bound    (left_bound),
        .right_bound   (right_bound),
        .done          (done),
        .column_out    (column_out),
        .status        (status),
        .entry_index   (entry_index),
        .match_length  (match_length),
        .witness_left  (witness_left),
        .witness_right (witness_right),
        .last          (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int eff_length();
        if (pattern_len == 0)
            return 1;
        if (pattern_len > PATTERN_MAX)
            return PATTERN_MAX;
        return int'(pattern_len);
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [SYM_W-1:0] pick_symbol();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return SYM_W'($urandom_range(0, 255));
        if (roll < 3)
            return SYM_W'($urandom_range(0, ALPHABET_SIZE - 1));
        return SYM_W'($urandom_range(0, 3));
    endfunction

    // Apply one transfer to the mirrored state and queue the results it causes.
    function automatic void predict_outcome(input logic [KIND_W-1:0] k,
                                            input logic [POS_W-1:0] pos,
                                            input logic [SYM_W-1:0] sym,
                                            input logic [COL_W-1:0] col,
                                            input logic [DEPTH_W-1:0] dep,
                                            input logic [BOUND_BITS-1:0] lb,
                                            input logic [BOUND_BITS-1:0] rb);
        outcome_t         r;
        int               n;
        int               d;
        logic [COL_W-1:0] len_mask;
        logic [COL_W-1:0] m;
        logic [COL_W-1:0] c;
        n = eff_length();
        d = int'(dep);
        len_mask = (n >= COL_W) ? '1 : ((64'd1 << n) - 64'd1);
        r = '0;
        r.last = 1'b1;
        case (k)
            KIND_LOAD:
            begin
                if (sym >= ALPHABET_SIZE)
                    r.status = STATUS_BAD_SYMBOL;
                else
                begin
                    for (int i = 0; i < ALPHABET_SIZE; i++)
                        symbol_mask[i][pos] = 1'b0;
                    symbol_mask[sym[SYM_IDX_W-1:0]][pos] = 1'b1;
                end
                expected_results.push_back(r);
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < ALPHABET_SIZE; i++)
                    symbol_mask[i] = '0;
                expected_results.push_back(r);
            end
            KIND_START:
            begin
                for (int i = 0; i < n; i++)
                begin
                    best_len[i] = '0;
                    best_left[i] = '0;
                    best_right[i] = '0;
                end
                r.column = '1;
                expected_results.push_back(r);
            end
            KIND_ADVANCE:
            begin
                if (sym >= ALPHABET_SIZE)
                    r.status = STATUS_BAD_SYMBOL;
                else
                begin
                    m = symbol_mask[sym[SYM_IDX_W-1:0]];
                    if (d <= 1)
                        r.column = m;
                    else if (d - 1 >= COL_W)
                        r.column = '0;
                    else
                        r.column = col & (m >> (d - 1));
                    r.status = ((r.column & len_mask) == '0) ? STATUS_STOP : STATUS_OK;
                end
                expected_results.push_back(r);
            end
            KIND_MATCH:
            begin
                c = col & len_mask;
                if (c == '0)
                    r.status = STATUS_STOP;
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        if (c[i] && best_len[i] < dep)
                        begin
                            best_len[i] = dep;
                            best_left[i] = lb;
                            best_right[i] = rb;
                        end
                    end
                end
                expected_results.push_back(r);
            end
            KIND_DUMP:
            begin
                for (int i = 0; i < n; i++)
                begin
                    r.index = INDEX_W'(i);
                    r.length = best_len[i];
                    r.left = best_left[i];
                    r.right = best_right[i];
                    r.last = (i == n - 1);
                    expected_results.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
        walk_column = r.column;
        walk_status = r.status;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: result with none expected, column_out %h, status %0d",
                         $time, column_out, status);
                mismatches++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                results_checked++;
                check_field("column_out", oldest.column, column_out);
                check_field("status", 64'(oldest.status), 64'(status));
                check_field("entry_index", 64'(oldest.index), 64'(entry_index));
                check_field("match_length", 64'(oldest.length), 64'(match_length));
                check_field("witness_left", 64'(oldest.left), 64'(witness_left));
                check_field("witness_right", 64'(oldest.right), 64'(witness_right));
                check_field("last", 64'(oldest.last), 64'(last));
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        repeat (CYCLE_LIMIT) @(posedge clk) cycle_count++;
        $display("Run stopped after %0d cycles with %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_item(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] pos,
                             input logic [SYM_W-1:0] sym, input logic [COL_W-1:0] col,
                             input logic [DEPTH_W-1:0] dep, input logic [BOUND_BITS-1:0] lb,
                             input logic [BOUND_BITS-1:0] rb);
        bit steady;
        steady = (items_sent >= 160 && items_sent < 260);
        if (!steady && $urandom_range(0, 99) < 24)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start       <= 1'b1;
        kind        <= k;
        position    <= pos;
        symbol      <= sym;
        column_in   <= col;
        depth       <= dep;
        left_bound  <= lb;
        right_bound <= rb;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_outcome(k, pos, sym, col, dep, lb, rb);
        if (k <= KIND_DUMP)
            items_sent++;
    endtask

    // Drain all results, then hold off so the block is idle.
    task automatic wait_quiet();
        start <= 1'b0;
        while (expected_results.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_pattern_length(input logic [CFG_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PATTERN_LENGTH;
        pwdata  <= {{(32 - CFG_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pattern_len = value;
        length_settings++;
    endtask

    task automatic read_pattern_length();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_PATTERN_LENGTH;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("pattern_length", 64'(pattern_len), 64'(prdata[CFG_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_config_access();
        read_pattern_length();
        write_pattern_length(7'd0);
        read_pattern_length();
        write_pattern_length(7'd127);
        read_pattern_length();
        write_pattern_length(7'd1);
        read_pattern_length();
        write_pattern_length(7'd64);
        read_pattern_length();
    endtask

    task automatic test_load_and_clear();
        send_item(KIND_LOAD, 6'd63, 8'd31, rnd64(), 8'd0, $urandom, $urandom);
        send_item(KIND_LOAD, 6'd0, 8'd0, rnd64(), 8'd0, $urandom, $urandom);
        send_item(KIND_LOAD, 6'd5, 8'd255, rnd64(), 8'd255, $urandom, $urandom);
        send_item(KIND_CLEAR, 6'd63, 8'd255, rnd64(), 8'd255, $urandom, $urandom);
        send_item(KIND_LOAD, 6'd0, 8'd1, '0, 8'd0, '0, '0);
        send_item(KIND_LOAD, 6'd1, 8'd2, '0, 8'd0, '0, '0);
        send_item(KIND_LOAD, 6'd2, 8'd1, '0, 8'd0, '0, '0);
        // Replace the character at position 2.
        send_item(KIND_LOAD, 6'd2, 8'd3, '1, 8'd0, '0, '0);
    endtask

    task automatic test_advance();
        send_item(KIND_START, 6'd0, 8'd0, rnd64(), 8'd7, $urandom, $urandom);
        send_item(KIND_ADVANCE, 6'd0, 8'd1, '0, 8'd0, '0, '0);
        send_item(KIND_ADVANCE, 6'd0, 8'd2, '0, 8'd1, '0, '0);
        send_item(KIND_ADVANCE, 6'd0, 8'd2, '1, 8'd2, '0, '0);
        send_item(KIND_ADVANCE, 6'd0, 8'd31, '1, 8'd64, '0, '0);
        send_item(KIND_ADVANCE, 6'd0, 8'd1, '1, 8'd65, '0, '0);
        send_item(KIND_ADVANCE, 6'd0, 8'd3, '1, 8'd255, '0, '0);
        send_item(KIND_ADVANCE, 6'd0, 8'd32, '1, 8'd2, '0, '0);
        send_item(KIND_SPARE_LO, 6'd3, 8'd1, rnd64(), 8'd1, $urandom, $urandom);
        send_item(KIND_SPARE_HI, 6'd3, 8'd1, rnd64(), 8'd1, $urandom, $urandom);
    endtask

    task automatic test_match_and_dump();
        send_item(KIND_MATCH, 6'd0, 8'd0, '0, 8'd5, '1, '1);
        send_item(KIND_MATCH, 6'd0, 8'd0, '1, 8'd255, '1, '1);
        send_item(KIND_MATCH, 6'd0, 8'd0, 64'd3, 8'd0, '0, '0);
        send_item(KIND_MATCH, 6'd0, 8'd0, 64'h00ff_0000_0000_0001, 8'd1, '0, '0);
        send_item(KIND_DUMP, 6'd0, 8'd0, '0, 8'd0, '0, '0);
        wait_quiet();
        write_pattern_length(7'd3);
        send_item(KIND_START, 6'd0, 8'd0, '0, 8'd0, '0, '0);
        // Drop bits above the pattern length.
        send_item(KIND_MATCH, 6'd0, 8'd0, 64'h8000_0000_0000_0000, 8'd9, '1, '1);
        send_item(KIND_MATCH, 6'd0, 8'd0, 64'h8000_0000_0000_0006, 8'd9, $urandom, $urandom);
        send_item(KIND_DUMP, 6'd0, 8'd0, '0, 8'd0, '0, '0);
        wait_quiet();
        write_pattern_length(7'd0);
        send_item(KIND_DUMP, 6'd0, 8'd0, '0, 8'd0, '0, '0);
        wait_quiet();
        write_pattern_length(7'd64);
    endtask

    task automatic test_random_search();
        int               target;
        int               steps;
        int               roll;
        logic [COL_W-1:0] col;
        logic [7:0]       dep;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_quiet();
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    write_pattern_length(7'd0);
                else if (roll == 1)
                    write_pattern_length(7'd127);
                else if (roll == 2)
                    write_pattern_length(7'd64);
                else if (roll == 3)
                    write_pattern_length(7'd1);
                else
                    write_pattern_length(CFG_W'($urandom_range(2, 63)));
            end
            if ($urandom_range(0, 1) == 0)
                send_item(KIND_CLEAR, POS_W'($urandom), SYM_W'($urandom), rnd64(),
                          DEPTH_W'($urandom), $urandom, $urandom);
            steps = $urandom_range(1, 12);
            repeat (steps)
                send_item(KIND_LOAD,
                          POS_W'(($urandom_range(0, 7) == 0)
                                 ? $urandom_range(0, 63)
                                 : $urandom_range(0, eff_length() - 1)),
                          pick_symbol(), rnd64(), DEPTH_W'($urandom), $urandom, $urandom);
            send_item(KIND_START, POS_W'($urandom), SYM_W'($urandom), rnd64(),
                      DEPTH_W'($urandom), $urandom, $urandom);
            col = walk_column;
            dep = 8'd1;
            steps = $urandom_range(1, 12);
            for (int i = 0; i < steps; i++)
            begin
                send_item(KIND_ADVANCE, POS_W'($urandom), pick_symbol(), col, dep, $urandom,
                          $urandom);
                col = walk_column;
                if ($urandom_range(0, 1) == 0)
                    send_item(KIND_MATCH, POS_W'($urandom), SYM_W'($urandom), col, dep,
                              $urandom, $urandom);
                if (walk_status != STATUS_OK && $urandom_range(0, 3) != 0)
                    break;
                dep = ($urandom_range(0, 9) == 0) ? DEPTH_W'($urandom_range(0, 255))
                                                  : dep + 8'd1;
            end
            if ($urandom_range(0, 2) == 0)
                send_item(KIND_DUMP, POS_W'($urandom), SYM_W'($urandom), rnd64(),
                          DEPTH_W'($urandom), $urandom, $urandom);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    send_item(KIND_W'($urandom_range(0, 7)), POS_W'($urandom),
                              SYM_W'($urandom), rnd64(), DEPTH_W'($urandom),
                              $urandom, $urandom);
        end
    endtask

    initial
    begin
        int directed_items;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        kind        <= KIND_LOAD;
        position    <= '0;
        symbol      <= '0;
        column_in   <= '0;
        depth       <= '0;
        left_bound  <= '0;
        right_bound <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= ADDR_PATTERN_LENGTH;
        pwdata      <= '0;
        items_sent = 0;
        results_checked = 0;
        mismatches = 0;
        length_settings = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_config_access();
        test_load_and_clear();
        test_advance();
        test_match_and_dump();
        wait_quiet();
        directed_items = items_sent;
        test_random_search();
        wait_quiet();
        $display("Covered %0d transfers (%0d directed) and %0d pattern length writes",
                 items_sent, directed_items, length_settings);
        $display("Checked %0d results in %0d cycles, %0d mismatches",
                 results_checked, cycle_count, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
